[hw/rtl/wtsc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package wtsc_pkg;

    localparam int MAX_COLUMNS_DEF   = 1024;
    localparam int ELEMENT_WIDTH_DEF = 16;

    localparam int TARGET_W = 18;
    localparam int ROW_W    = 16;
    localparam int COL_W    = 11;
    localparam int TOTAL_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    localparam logic signed [TARGET_W-1:0] TARGET_RST = 18'sd10;
    localparam logic [ROW_W-1:0]           ROWS_RST   = 16'd3;
    localparam logic [COL_W-1:0]           COLS_RST   = 11'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET = 2'd0,
        CFG_ROWS   = 2'd1,
        CFG_COLS   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic col_ge2;
        logic row_ge2;
        logic anti_ok;
        logic frame_end;
    } t_item_ctl;

endpackage

`default_nettype wire

[hw/rtl/wtsc_line_store.sv]
`timescale 1ns / 1ps
`default_nettype none

module wtsc_line_store #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr_a,
    input  wire logic [AW-1:0]    i_rd_addr_b,
    output logic      [WIDTH-1:0] o_rd_data_a,
    output logic      [WIDTH-1:0] o_rd_data_b,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rd_data_a;
    logic [WIDTH-1:0] r_rd_data_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            // write in the same cycle wins over the stored word
            if (i_wr_en && (i_wr_addr == i_rd_addr_a)) begin
                r_rd_data_a <= i_wr_data;
            end else begin
                r_rd_data_a <= mem[i_rd_addr_a];
            end
            if (i_wr_en && (i_wr_addr == i_rd_addr_b)) begin
                r_rd_data_b <= i_wr_data;
            end else begin
                r_rd_data_b <= mem[i_rd_addr_b];
            end
        end
    end

    assign o_rd_data_a = r_rd_data_a;
    assign o_rd_data_b = r_rd_data_b;

endmodule

`default_nettype wire

[hw/rtl/wtsc_window_match.sv]
`timescale 1ns / 1ps
`default_nettype none

module wtsc_window_match
    import wtsc_pkg::*;
#(
    parameter int EW = ELEMENT_WIDTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_advance,
    input  wire logic signed [EW-1:0]       i_x,
    input  wire logic signed [EW-1:0]       i_up1,
    input  wire logic signed [EW-1:0]       i_up2,
    input  wire logic signed [EW-1:0]       i_anti1,
    input  wire logic signed [EW-1:0]       i_anti2,
    input  wire t_item_ctl                  i_ctl,
    input  wire logic signed [TARGET_W-1:0] i_target,
    output logic             [TOTAL_W-1:0]  o_total,
    output logic                            o_sat
);

    localparam int SW = (EW + 2 > TARGET_W) ? EW + 2 : TARGET_W;

    // 0/1 current row, 2/3 row above, 4/5 two rows above; even = c-1, odd = c-2
    logic signed [EW-1:0] r_win [0:5];
    logic [TOTAL_W-1:0]   r_total;
    logic                 r_sat;

    logic signed [SW-1:0] tgt;
    logic signed [SW-1:0] sum_h;
    logic signed [SW-1:0] sum_v;
    logic signed [SW-1:0] sum_d;
    logic signed [SW-1:0] sum_a;
    logic [2:0]           hits;
    logic [TOTAL_W:0]     sum_total;
    logic [TOTAL_W-1:0]   n_total;
    logic                 n_sat;

    always_comb begin
        tgt   = SW'(i_target);
        sum_h = SW'(i_x) + SW'(r_win[0]) + SW'(r_win[1]);
        sum_v = SW'(i_x) + SW'(i_up1) + SW'(i_up2);
        sum_d = SW'(i_x) + SW'(r_win[2]) + SW'(r_win[5]);
        sum_a = SW'(i_x) + SW'(i_anti1) + SW'(i_anti2);
        hits  = 3'(i_ctl.col_ge2 && (sum_h == tgt))
              + 3'(i_ctl.row_ge2 && (sum_v == tgt))
              + 3'(i_ctl.row_ge2 && i_ctl.col_ge2 && (sum_d == tgt))
              + 3'(i_ctl.anti_ok && (sum_a == tgt));
        sum_total = {1'b0, r_total} + (TOTAL_W + 1)'(hits);
        if (sum_total[TOTAL_W]) begin
            n_total = '1;
            n_sat   = 1'b1;
        end else begin
            n_total = sum_total[TOTAL_W-1:0];
            n_sat   = r_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_win[1] <= r_win[0];
            r_win[0] <= i_x;
            r_win[3] <= r_win[2];
            r_win[2] <= i_up1;
            r_win[5] <= r_win[4];
            r_win[4] <= i_up2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_sat   <= 1'b0;
        end else if (i_advance) begin
            if (i_ctl.frame_end) begin
                r_total <= '0;
                r_sat   <= 1'b0;
            end else begin
                r_total <= n_total;
                r_sat   <= n_sat;
            end
        end
    end

    assign o_total = n_total;
    assign o_sat   = n_sat;

endmodule

`default_nettype wire

[hw/rtl/window_triple_sum_counter_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// the total item is loaded into the result register when the last element item leaves the s1 stage
// throughput: one element item per cycle, set by one read pass of the line stores
//   (two read ports each) and one write back per item, unless a frame-end item waits on an unread total
// reset: synchronous active low, clears positions, total and valid flags, loads the config
//   registers with their reset values; line stores and window are not cleared, no clearing pass
module window_triple_sum_counter_core
    import wtsc_pkg::*;
#(
    parameter int MAX_COLUMNS   = MAX_COLUMNS_DEF,
    parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    input  wire logic [((ELEMENT_WIDTH+7)/8)*8-1:0]  i_s_tdata,   // element
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    output logic [TOTAL_W-1:0]                       o_m_tdata,   // total_runs
    output logic                                     o_m_tuser,   // saturated
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]                i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]               i_cfg_data
);

    localparam int EW = ELEMENT_WIDTH;
    localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int NW = (AW + 1 > COL_W) ? AW + 1 : COL_W;

    logic signed [TARGET_W-1:0] r_target;
    logic [ROW_W-1:0]           r_rows;
    logic [COL_W-1:0]           r_cols;

    logic [AW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;

    logic                 r_s1_valid;
    logic signed [EW-1:0] r_s1_x;
    logic [AW-1:0]        r_s1_col;
    t_item_ctl            r_s1_ctl;

    logic               r_out_valid;
    logic [TOTAL_W-1:0] r_out_total;
    logic               r_out_sat;

    logic [NW-1:0]      n_cols;
    logic [ROW_W-1:0]   n_rows;
    logic [NW-1:0]      col_ext;
    logic               last_col;
    logic               last_row;
    t_item_ctl          item_ctl;
    logic               s_accept;
    logic               s1_go;
    logic [EW-1:0]      up1;
    logic [EW-1:0]      up2;
    logic [EW-1:0]      anti1;
    logic [EW-1:0]      anti2;
    logic [TOTAL_W-1:0] res_total;
    logic               res_sat;

    // effective frame size and per-item position flags
    always_comb begin
        n_cols = (r_cols == '0) ? NW'(1) : NW'(r_cols);
        if (n_cols > NW'(MAX_COLUMNS)) begin
            n_cols = NW'(MAX_COLUMNS);
        end
        n_rows = (r_rows == '0) ? ROW_W'(1) : r_rows;
        col_ext  = NW'(r_col);
        last_col = (col_ext + NW'(1)) >= n_cols;
        last_row = ((ROW_W + 1)'(r_row) + (ROW_W + 1)'(1)) >= (ROW_W + 1)'(n_rows);
        item_ctl.col_ge2   = col_ext >= NW'(2);
        item_ctl.row_ge2   = r_row >= ROW_W'(2);
        item_ctl.anti_ok   = (r_row >= ROW_W'(2)) && ((col_ext + NW'(2)) < n_cols);
        item_ctl.frame_end = last_col && last_row;
    end

    assign s1_go      = r_s1_valid && (!r_s1_ctl.frame_end || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || s1_go;
    assign s_accept   = i_s_tvalid && o_s_tready;

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= TARGET_RST;
            r_rows   <= ROWS_RST;
            r_cols   <= COLS_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TARGET: r_target <= $signed(i_cfg_data[TARGET_W-1:0]);
                CFG_ROWS:   r_rows   <= i_cfg_data[ROW_W-1:0];
                CFG_COLS:   r_cols   <= i_cfg_data[COL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // raster position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (s_accept) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= AW'(col_ext + NW'(1));
            end
        end
    end

    // item in flight while the line stores answer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_x   <= $signed(i_s_tdata[EW-1:0]);
            r_s1_col <= r_col;
            r_s1_ctl <= item_ctl;
        end
    end

    wtsc_line_store #(
        .DEPTH (MAX_COLUMNS),
        .WIDTH (EW),
        .AW    (AW)
    ) u_above (
        .i_clk       (i_clk),
        .i_rd_en     (s_accept),
        .i_rd_addr_a (r_col),
        .i_rd_addr_b (AW'(col_ext + NW'(1))),
        .o_rd_data_a (up1),
        .o_rd_data_b (anti1),
        .i_wr_en     (s1_go),
        .i_wr_addr   (r_s1_col),
        .i_wr_data   (r_s1_x)
    );

    wtsc_line_store #(
        .DEPTH (MAX_COLUMNS),
        .WIDTH (EW),
        .AW    (AW)
    ) u_two_above (
        .i_clk       (i_clk),
        .i_rd_en     (s_accept),
        .i_rd_addr_a (r_col),
        .i_rd_addr_b (AW'(col_ext + NW'(2))),
        .o_rd_data_a (up2),
        .o_rd_data_b (anti2),
        .i_wr_en     (s1_go),
        .i_wr_addr   (r_s1_col),
        .i_wr_data   (up1)
    );

    wtsc_window_match #(
        .EW (EW)
    ) u_match (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (s1_go),
        .i_x       (r_s1_x),
        .i_up1     ($signed(up1)),
        .i_up2     ($signed(up2)),
        .i_anti1   ($signed(anti1)),
        .i_anti2   ($signed(anti2)),
        .i_ctl     (r_s1_ctl),
        .i_target  (r_target),
        .o_total   (res_total),
        .o_sat     (res_sat)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1_ctl.frame_end) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_ctl.frame_end) begin
            r_out_total <= res_total;
            r_out_sat   <= res_sat;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_total;
    assign o_m_tuser  = r_out_sat;

endmodule

`default_nettype wire

[bench/window_triple_sum_counter_core_checker.sv]
`timescale 1ns / 1ps

module window_triple_sum_counter_core_checker
    import wtsc_pkg::*;
(
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    input  wire logic                                          i_s_tvalid,
    input  wire logic                                          i_s_tready,
    input  wire logic [((ELEMENT_WIDTH_DEF+7)/8)*8-1:0]        i_s_tdata,   // element
    input  wire logic                                          i_m_tvalid,
    input  wire logic                                          i_m_tready,
    input  wire logic [TOTAL_W-1:0]                            i_m_tdata,   // total_runs
    input  wire logic                                          i_m_tuser,   // saturated
    input  wire logic                                          i_cfg_valid,
    input  wire logic                                          i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]                          i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]                         i_cfg_data,
    output int                                                 o_fail_count,
    output int                                                 o_pending,
    output int                                                 o_totals_checked
);

    localparam int ELEM_W   = ELEMENT_WIDTH_DEF;
    localparam int MAX_COLS = MAX_COLUMNS_DEF;

    typedef logic signed [ELEM_W-1:0] t_elem;

    typedef struct packed {
        logic [TOTAL_W-1:0] runs;
        logic               saturated;
    } t_frame_total;

    t_elem                      above_row [MAX_COLS];
    t_elem                      two_above_row [MAX_COLS];
    t_elem                      win [6];
    int                         row_pos;
    int                         col_pos;
    logic [TOTAL_W-1:0]         run_total;
    logic                       sat_flag;
    logic signed [TARGET_W-1:0] target_q;
    logic [ROW_W-1:0]           rows_q;
    logic [COL_W-1:0]           cols_q;
    t_frame_total               expected_totals [$];
    int                         fail_count;
    int                         totals_checked;

    initial begin
        fail_count     = 0;
        totals_checked = 0;
        foreach (above_row[k]) begin
            above_row[k]     = '0;
            two_above_row[k] = '0;
        end
        foreach (win[k]) begin
            win[k] = '0;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    function automatic logic sums_to_target(input t_elem a, input t_elem b, input t_elem d);
        return (int'(a) + int'(b) + int'(d)) == int'(target_q);
    endfunction

    task automatic count_window_runs(input t_elem x);
        int                 ncols;
        int                 nrows;
        int                 hits;
        int                 c;
        int                 r;
        t_elem              up1;
        t_elem              up2;
        t_frame_total       done;
        logic [TOTAL_W:0]   widened;
        ncols = (cols_q == 0) ? 1 : ((int'(cols_q) > MAX_COLS) ? MAX_COLS : int'(cols_q));
        nrows = (rows_q == 0) ? 1 : int'(rows_q);
        c     = col_pos;
        r     = row_pos;
        up1   = above_row[c];
        up2   = two_above_row[c];
        hits  = 0;

        // horizontal, vertical, diagonal, anti-diagonal
        if (c >= 2 && sums_to_target(x, win[0], win[1]))
            hits++;
        if (r >= 2 && sums_to_target(x, up1, up2))
            hits++;
        if (r >= 2 && c >= 2 && sums_to_target(x, win[2], win[5]))
            hits++;
        if (r >= 2 && c + 2 < ncols && sums_to_target(x, above_row[c+1], two_above_row[c+2]))
            hits++;

        two_above_row[c] = up1;
        above_row[c]     = x;
        win[1] = win[0];
        win[0] = x;
        win[3] = win[2];
        win[2] = up1;
        win[5] = win[4];
        win[4] = up2;

        widened = {1'b0, run_total} + hits;
        if (widened > {1'b0, {TOTAL_W{1'b1}}}) begin
            run_total = '1;
            sat_flag  = 1'b1;
        end else begin
            run_total = widened[TOTAL_W-1:0];
        end

        if (c + 1 >= ncols) begin
            col_pos = 0;
            if (r + 1 >= nrows) begin
                done.runs      = run_total;
                done.saturated = sat_flag;
                expected_totals.push_back(done);
                row_pos   = 0;
                run_total = '0;
                sat_flag  = 1'b0;
            end else begin
                row_pos = r + 1;
            end
        end else begin
            col_pos = c + 1;
        end
    endtask

    task automatic check_total();
        t_frame_total want;
        if (expected_totals.size() == 0) begin
            report_mismatch($sformatf("total %0d arrived with no frame pending", i_m_tdata));
        end else begin
            want = expected_totals.pop_front();
            if (i_m_tdata !== want.runs)
                report_mismatch($sformatf("total_runs %0d, expected %0d", i_m_tdata, want.runs));
            if (i_m_tuser !== want.saturated)
                report_mismatch($sformatf("saturated %b, expected %b", i_m_tuser,
                                          want.saturated));
            totals_checked++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            row_pos   = 0;
            col_pos   = 0;
            run_total = '0;
            sat_flag  = 1'b0;
            target_q  = TARGET_RST;
            rows_q    = ROWS_RST;
            cols_q    = COLS_RST;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TARGET: target_q = i_cfg_data[TARGET_W-1:0];
                    CFG_ROWS:   rows_q   = i_cfg_data[ROW_W-1:0];
                    CFG_COLS:   cols_q   = i_cfg_data[COL_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                count_window_runs(i_s_tdata[ELEM_W-1:0]);
            if (i_m_tvalid && i_m_tready)
                check_total();
        end
        o_fail_count     <= fail_count;
        o_pending        <= expected_totals.size();
        o_totals_checked <= totals_checked;
    end

endmodule

[bench/window_triple_sum_counter_core_tb.sv]
`timescale 1ns / 1ps

module window_triple_sum_counter_core_tb;
    import wtsc_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int ELEM_W       = ELEMENT_WIDTH_DEF;
    localparam int DATA_W       = ((ELEM_W + 7) / 8) * 8;
    localparam int RESET_CYCLES = 5;
    localparam int DRAIN_CYCLES = 6;
    localparam int STALL_LIMIT  = 5000;
    localparam int PHASE_ITEMS  = 200;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef logic signed [ELEM_W-1:0] t_elem;

    typedef enum int {
        ELEMS_NARROW,
        ELEMS_FULL,
        ELEMS_EXTREME
    } t_elem_mix;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_reg_write;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [DATA_W-1:0]     i_s_tdata   = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [TOTAL_W-1:0]    o_m_tdata;
    logic                  o_m_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    int         fail_count;
    int         pending;
    int         totals_checked;
    int         src_idle_pct  = 0;
    int         snk_stall_pct = 0;
    int         items_sent    = 0;
    int         frames_sent   = 0;
    t_reg_write reg_writes [$];

    window_triple_sum_counter_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    window_triple_sum_counter_core_checker totals_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_tvalid       (i_s_tvalid),
        .i_s_tready       (o_s_tready),
        .i_s_tdata        (i_s_tdata),
        .i_m_tvalid       (o_m_tvalid),
        .i_m_tready       (i_m_tready),
        .i_m_tdata        (o_m_tdata),
        .i_m_tuser        (o_m_tuser),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_totals_checked (totals_checked)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    function automatic t_elem pick_element(input t_elem_mix mix);
        case (mix)
            ELEMS_NARROW: return t_elem'(int'($urandom_range(8)) - 2);
            ELEMS_FULL:   return t_elem'($urandom);
            default: begin
                case ($urandom_range(4))
                    0:       return 16'sh8000;
                    1:       return 16'sh7fff;
                    2:       return 16'sh0000;
                    3:       return -16'sd1;
                    default: return 16'sd1;
                endcase
            end
        endcase
    endfunction

    function automatic int pick_target(input t_elem_mix mix);
        case (mix)
            ELEMS_NARROW: return int'($urandom_range(16)) - 4;
            ELEMS_FULL: begin
                if ($urandom_range(1) == 0)
                    return int'($urandom);
                return int'(t_elem'($urandom)) + int'(t_elem'($urandom))
                       + int'(t_elem'($urandom));
            end
            default: begin
                case ($urandom_range(7))
                    0:       return -98304;
                    1:       return 98301;
                    2:       return 0;
                    3:       return -1;
                    4:       return -65536;
                    5:       return 65534;
                    6:       return -131072;
                    default: return 131071;
                endcase
            end
        endcase
    endfunction

    task automatic send_element(input t_elem x);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= x;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_frame(input t_elem_mix mix, input int count);
        for (int k = 0; k < count; k++)
            send_element(pick_element(mix));
        frames_sent++;
    endtask

    // sender holds off until every frame total has come back
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic stage_frame(input int target, input int rows, input int cols);
        reg_writes.push_back('{CFG_TARGET, CFG_DATA_W'(target)});
        reg_writes.push_back('{CFG_ROWS, CFG_DATA_W'(rows)});
        reg_writes.push_back('{CFG_COLS, CFG_DATA_W'(cols)});
    endtask

    task automatic apply_regs();
        t_reg_write w;
        while (reg_writes.size() != 0) begin
            w = reg_writes.pop_front();
            i_cfg_valid <= 1'b1;
            i_cfg_index <= w.idx;
            i_cfg_data  <= w.data;
            @(posedge i_clk);
            while (!o_cfg_ready)
                @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_group(input t_elem_mix mix, input int target, input int rows,
                             input int cols, input int nframes);
        int eff_rows;
        int eff_cols;
        eff_rows = (rows == 0) ? 1 : rows;
        eff_cols = (cols == 0) ? 1 : ((cols > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : cols);
        drain_results();
        stage_frame(target, rows, cols);
        apply_regs();
        for (int f = 0; f < nframes; f++)
            send_frame(mix, eff_rows * eff_cols);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        int        phase_start;
        int        rows;
        int        cols;
        t_elem_mix mix;
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        phase_start   = items_sent;
        while (items_sent - phase_start < PHASE_ITEMS) begin
            case ($urandom_range(19))
                0, 1, 2, 3, 4:  mix = ELEMS_FULL;
                5, 6, 7:        mix = ELEMS_EXTREME;
                default:        mix = ELEMS_NARROW;
            endcase
            case ($urandom_range(19))
                0:       rows = 0;
                1:       rows = $urandom_range(20, 12);
                default: rows = $urandom_range(6, 1);
            endcase
            case ($urandom_range(19))
                0:       cols = 0;
                1:       cols = $urandom_range(40, 9);
                default: cols = $urandom_range(8, 1);
            endcase
            run_group(mix, pick_target(mix), rows, cols, $urandom_range(3, 1));
        end
    endtask

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
        $display("** window_triple_sum_counter_core: FAILED **");
        $finish;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings, a 3x3 frame with most runs summing to ten
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                send_element((r + c == 2) ? 16'sd4 : 16'sd3);
        frames_sent++;

        // every direction hits
        drain_results();
        stage_frame(12, 3, 3);
        apply_regs();
        for (int k = 0; k < 9; k++)
            send_element(16'sd4);
        frames_sent++;

        // single row, lowest target
        drain_results();
        stage_frame(-98304, 1, 3);
        apply_regs();
        for (int k = 0; k < 3; k++)
            send_element(16'sh8000);
        frames_sent++;

        // zero columns act as one, highest target
        drain_results();
        stage_frame(98301, 3, 0);
        apply_regs();
        for (int k = 0; k < 3; k++)
            send_element(16'sh7fff);
        frames_sent++;

        // zero size both ways, plus a write to the unused index
        drain_results();
        stage_frame(0, 0, 0);
        reg_writes.push_back('{CFG_SPARE, CFG_DATA_W'($urandom)});
        apply_regs();
        send_element(16'sd0);
        frames_sent++;

        run_phase(0, 0);
        run_phase(67, 0);
        run_phase(0, 67);
        run_phase(32, 32);
        run_group(ELEMS_FULL, int'($urandom), 1, 1, 2);
        drain_results();

        $display("covered %0d frames, %0d element items, four sender/receiver idle mixes",
                 frames_sent, items_sent);
        $display("%0d frame totals compared, incl. one-row, one-column and zero-size frames",
                 totals_checked);
        if (fail_count == 0 && pending == 0)
            $display("** window_triple_sum_counter_core: PASSED **");
        else
            $display("** window_triple_sum_counter_core: FAILED **");
        $finish;
    end

endmodule
